@@ design/dsti_pkg.sv @@
`default_nettype none

package dsti_pkg;

    // Character codes recognized by the parser
    localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CHAR_UPA   = 8'h41;  // 'A'
    localparam logic [7:0] CHAR_UPZ   = 8'h5A;  // 'Z'
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CHAR_TILDE = 8'h7E;  // '~'
    localparam logic [5:0] LETTER_BASE = 6'd10;

    // Configuration register map
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned RADIX_W  = 6;
    localparam int unsigned DIGIT_W  = 6;
    localparam int unsigned APB_DW   = 32;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic REG_RADIX_IDX = 1'b0;  // word index of the radix register

    // Queue between front and back
    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned PTR_W      = 1;
    localparam int unsigned CNT_W      = 2;

    // Character class decided by the front
    typedef enum logic [2:0] {
        KIND_PLUS,
        KIND_MINUS,
        KIND_TILDE,
        KIND_DIGIT,
        KIND_BAD
    } char_kind_t;

    // One classified character
    typedef struct packed {
        char_kind_t           kind;
        logic [DIGIT_W-1:0]   digit;
        logic                 last;
    } dsti_item_t;

endpackage

`default_nettype wire

@@ design/digit_string_to_integer.sv @@
// Parses signed integers from a character stream, one ASCII character per
// transfer, in the base held in the radix register (byte address 0, reset 10).
// A leading '+', '-' or '~' gives a plain, negated or inverted result; digits
// are '0'-'9' and 'A'-'Z'. The character with is_last set produces one result
// transfer carrying value and ok; value is zero when ok is low. A character is
// taken every cycle while the queue is not full; the back stage does one
// multiply-add by the radix per cycle while its output is free, and a two-entry
// queue lets input and output stall independently. Each result is registered.
// Write the radix only while no string is in flight.
`default_nettype none

module digit_string_to_integer
    import dsti_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    // character input
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_char_code,
    input  wire logic              s_is_last,
    // result output
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic signed [31:0]     m_value,
    output logic                   m_ok
);

    logic [RADIX_W-1:0] radix_reg, radix_next;
    logic               reg_sel;
    logic               fifo_full;
    logic               push;
    logic               pop;
    logic               head_valid;
    dsti_item_t         push_item;
    dsti_item_t         head_item;

    // Register access
    assign pready  = 1'b1;
    assign reg_sel = (paddr[ADDR_W-1] == REG_RADIX_IDX);
    assign prdata  = reg_sel ? APB_DW'(radix_reg) : '0;

    always_comb begin
        radix_next = radix_reg;
        if (psel && penable && pwrite && reg_sel) begin
            radix_next = pwdata[RADIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else begin
            radix_reg <= radix_next;
        end
    end

    dsti_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .char_code (s_char_code),
        .is_last   (s_is_last),
        .fifo_full (fifo_full),
        .push      (push),
        .item      (push_item)
    );

    dsti_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    dsti_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .radix    (radix_reg),
        .in_valid (head_valid),
        .in_item  (head_item),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_value  (m_value),
        .m_ok     (m_ok)
    );

endmodule

`default_nettype wire

@@ design/dsti_front.sv @@
`default_nettype none

module dsti_front
    import dsti_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] char_code,
    input  wire logic       is_last,
    input  wire logic       fifo_full,
    output logic            push,
    output dsti_item_t      item
);

    logic first_reg;
    logic first_next;

    assign s_ready = ~fifo_full;
    assign push    = s_valid & s_ready;

    // Track the first character of each string
    always_comb begin
        first_next = first_reg;
        if (push) begin
            first_next = is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
        end else begin
            first_reg <= first_next;
        end
    end

    // Classify the character; signs count only as the first character
    always_comb begin
        item.last  = is_last;
        item.digit = '0;
        item.kind  = KIND_BAD;
        if (first_reg && char_code == CHAR_PLUS) begin
            item.kind = KIND_PLUS;
        end else if (first_reg && char_code == CHAR_MINUS) begin
            item.kind = KIND_MINUS;
        end else if (first_reg && char_code == CHAR_TILDE) begin
            item.kind = KIND_TILDE;
        end else if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE) begin
            item.kind  = KIND_DIGIT;
            item.digit = DIGIT_W'(char_code - CHAR_ZERO);
        end else if (char_code >= CHAR_UPA && char_code <= CHAR_UPZ) begin
            item.kind  = KIND_DIGIT;
            item.digit = DIGIT_W'(char_code - CHAR_UPA) + LETTER_BASE;
        end
    end

endmodule

`default_nettype wire

@@ design/dsti_fifo.sv @@
`default_nettype none

module dsti_fifo
    import dsti_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  dsti_item_t       push_item,
    output logic             full,
    input  wire logic        pop,
    output logic             head_valid,
    output dsti_item_t       head_item
);

    dsti_item_t       mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ design/dsti_back.sv @@
`default_nettype none

module dsti_back
    import dsti_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [RADIX_W-1:0] radix,
    input  wire logic               in_valid,
    input  dsti_item_t              in_item,
    output logic                    pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_value,
    output logic                    m_ok
);

    localparam int unsigned PW = VALUE_BITS + RADIX_W;

    logic                  neg_reg, neg_next;
    logic                  inv_reg, inv_next;
    logic                  seen_reg, seen_next;
    logic                  failed_reg, failed_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  m_valid_reg, m_valid_next;
    logic [31:0]           m_value_reg, m_value_next;
    logic                  m_ok_reg, m_ok_next;

    logic [PW-1:0]         prod;
    logic [PW-1:0]         limit;
    logic                  good;
    logic [VALUE_BITS-1:0] res_v;
    logic [31:0]           res_32;
    logic                  out_free;

    assign out_free = ~m_valid_reg | m_ready;
    assign pop      = in_valid & out_free;

    // Multiply-add and range limit, one more for negated strings
    assign prod  = PW'(acc_reg) * PW'(radix) + PW'(in_item.digit);
    assign limit = (PW'(1) << (VALUE_BITS - 1)) - (neg_reg ? PW'(0) : PW'(1));

    // String state update for the character at the queue head
    always_comb begin
        neg_next    = neg_reg;
        inv_next    = inv_reg;
        seen_next   = seen_reg;
        failed_next = failed_reg;
        acc_next    = acc_reg;
        if (!failed_reg) begin
            case (in_item.kind)
                KIND_PLUS: begin
                end
                KIND_MINUS: begin
                    neg_next = 1'b1;
                end
                KIND_TILDE: begin
                    inv_next = 1'b1;
                end
                KIND_DIGIT: begin
                    if (in_item.digit >= radix || prod > limit) begin
                        failed_next = 1'b1;
                    end else begin
                        acc_next  = prod[VALUE_BITS-1:0];
                        seen_next = 1'b1;
                    end
                end
                default: begin
                    failed_next = 1'b1;
                end
            endcase
        end
    end

    // Final value after sign or inversion
    always_comb begin
        good  = ~failed_next & seen_next;
        res_v = '0;
        if (good) begin
            res_v = acc_next;
            if (neg_next) begin
                res_v = '0 - res_v;
            end
            if (inv_next) begin
                res_v = ~res_v;
            end
        end
    end

    generate
        if (VALUE_BITS >= 32) begin : g_trunc
            assign res_32 = res_v[31:0];
        end else begin : g_ext
            assign res_32 = {{(32 - VALUE_BITS){1'b0}}, res_v};
        end
    endgenerate

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg & ~m_ready;
        m_value_next = m_value_reg;
        m_ok_next    = m_ok_reg;
        if (pop && in_item.last) begin
            m_valid_next = 1'b1;
            m_value_next = res_32;
            m_ok_next    = good;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            neg_reg     <= 1'b0;
            inv_reg     <= 1'b0;
            seen_reg    <= 1'b0;
            failed_reg  <= 1'b0;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                if (in_item.last) begin
                    neg_reg    <= 1'b0;
                    inv_reg    <= 1'b0;
                    seen_reg   <= 1'b0;
                    failed_reg <= 1'b0;
                    acc_reg    <= '0;
                end else begin
                    neg_reg    <= neg_next;
                    inv_reg    <= inv_next;
                    seen_reg   <= seen_next;
                    failed_reg <= failed_next;
                    acc_reg    <= acc_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_value_reg <= m_value_next;
        m_ok_reg    <= m_ok_next;
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;
    assign m_ok    = m_ok_reg;

endmodule

`default_nettype wire

@@ test/tb_digit_string_to_integer.sv @@
`default_nettype none

module tb_digit_string_to_integer;
    import dsti_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned VALUE_BITS = 32;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned LONG_HOLD = 300;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } char_item_t;

    typedef struct packed {
        logic [31:0] value;
        logic        ok;
    } number_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [APB_DW-1:0]     pwdata = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_char_code = '0;
    logic                  s_is_last = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic signed [31:0]    m_value;
    logic                  m_ok;

    digit_string_to_integer #(
        .VALUE_BITS(VALUE_BITS)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_char_code(s_char_code),
        .s_is_last(s_is_last),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_value(m_value),
        .m_ok(m_ok)
    );

    // Stimulus and expectation stores
    char_item_t   pending_chars[$];
    number_t      expected_numbers[$];
    logic [7:0]   num_text[$];

    int unsigned  mismatch_count = 0;
    int unsigned  results_seen = 0;
    int unsigned  cycle_count = 0;
    logic         char_taken = 1'b0;

    // Parser state mirrored in the testbench
    logic [5:0]   cfg_radix = RADIX_RESET;
    logic         st_at_start = 1'b1;
    logic         st_neg = 1'b0;
    logic         st_inv = 1'b0;
    logic         st_digit_seen = 1'b0;
    logic         st_failed = 1'b0;
    logic [32:0]  st_mag = '0;

    // Source and sink pacing
    int unsigned  src_gap = 0;
    bit           src_quiet = 1'b0;
    char_item_t   cur_item;
    int unsigned  snk_stall = 0;
    int unsigned  snk_hold = 0;
    int unsigned  holds_done = 0;
    bit           snk_quiet = 1'b0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Weight of a digit symbol; 64 marks a non-digit
    function automatic logic [6:0] symbol_weight(input logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE) return 7'(c - CHAR_ZERO);
        if (c >= CHAR_UPA && c <= CHAR_UPZ) return 7'(c - CHAR_UPA) + 7'(LETTER_BASE);
        return 7'd64;
    endfunction

    // Mostly short gaps, some medium, a few long; none in quiet stretches
    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Advance the parser by one character; push a result on the last one
    task automatic parse_char(input logic [7:0] c, input logic last);
        logic        first;
        logic [6:0]  d;
        logic [63:0] lim;
        logic [63:0] v;
        logic        good;
        number_t     num;
        first = st_at_start;
        st_at_start = 1'b0;
        if (!st_failed) begin
            if (first && c == CHAR_PLUS) begin
                // plain result, nothing to record
            end else if (first && c == CHAR_MINUS) begin
                st_neg = 1'b1;
            end else if (first && c == CHAR_TILDE) begin
                st_inv = 1'b1;
            end else begin
                d = symbol_weight(c);
                lim = (64'd1 << (VALUE_BITS - 1)) - (st_neg ? 64'd0 : 64'd1);
                if (d >= 7'(cfg_radix)) begin
                    st_failed = 1'b1;
                end else if (64'(st_mag) > (lim - 64'(d)) / 64'(cfg_radix)) begin
                    st_failed = 1'b1;
                end else begin
                    st_mag = 33'(64'(st_mag) * 64'(cfg_radix) + 64'(d));
                    st_digit_seen = 1'b1;
                end
            end
        end
        if (last) begin
            good = !st_failed && st_digit_seen;
            v = '0;
            if (good) begin
                v = 64'(st_mag);
                if (st_neg) v = -v;
                if (st_inv) v = ~v;
            end
            num.value = v[31:0];
            num.ok = good;
            expected_numbers.push_back(num);
            st_at_start = 1'b1;
            st_neg = 1'b0;
            st_inv = 1'b0;
            st_digit_seen = 1'b0;
            st_failed = 1'b0;
            st_mag = '0;
        end
    endtask

    task automatic push_char(input logic [7:0] c, input logic last);
        char_item_t it;
        it.code = c;
        it.last = last;
        pending_chars.push_back(it);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
    endtask

    // Send the scratch text as one string
    task automatic flush_text();
        foreach (num_text[i]) push_char(num_text[i], i == num_text.size() - 1);
        num_text.delete();
    endtask

    // Write a magnitude in the given base (2..36) into the scratch text
    task automatic spell_number(input logic [63:0] mag, input int unsigned base);
        logic [63:0] m;
        int unsigned d;
        num_text.delete();
        m = mag;
        do begin
            d = int'(m % base);
            num_text.push_front(d < 10 ? 8'(CHAR_ZERO + d) : 8'(CHAR_UPA + d - 10));
            m = m / base;
        end while (m != 0);
    endtask

    // One random string: mostly well-formed, some corrupted, some pure noise
    task automatic push_random_string();
        int unsigned base;
        int unsigned kind;
        int unsigned n;
        int unsigned r;
        logic [63:0] mag;
        logic [7:0]  bad;
        base = (cfg_radix > 36) ? 36 : cfg_radix;
        kind = $urandom_range(0, 99);
        if (kind >= 88) begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) push_char(8'($urandom_range(0, 255)), i == n - 1);
        end else begin
            if (base < 2) begin
                num_text.delete();
                n = $urandom_range(0, 3);
                repeat (n) begin
                    num_text.push_back(base == 1 ? CHAR_ZERO :
                                       8'(CHAR_ZERO + $urandom_range(0, 9)));
                end
            end else begin
                r = $urandom_range(0, 9);
                if (r < 4) mag = 64'($urandom_range(0, base * base * base));
                else if (r < 7) mag = 64'($urandom());
                else mag = 64'h8000_0000 - 64'd2 + 64'($urandom_range(0, 3));
                spell_number(mag, base);
                if ($urandom_range(0, 7) == 0) num_text.push_front(CHAR_ZERO);
                if ($urandom_range(0, 30) == 0) num_text.delete();
            end
            // corruption: lower case, late sign, out-of-base digit or any byte
            if (kind >= 72) begin
                case ($urandom_range(0, 3))
                    0: bad = 8'("a" + $urandom_range(0, 25));
                    1: bad = ($urandom_range(0, 1) != 0) ? CHAR_MINUS : CHAR_TILDE;
                    2: bad = (base < 36) ? 8'(CHAR_UPZ - $urandom_range(0, 35 - base)) : CHAR_PLUS;
                    default: bad = 8'($urandom_range(0, 255));
                endcase
                num_text.insert($urandom_range(0, num_text.size()), bad);
            end
            case ($urandom_range(0, 3))
                1: num_text.push_front(CHAR_PLUS);
                2: num_text.push_front(CHAR_MINUS);
                3: num_text.push_front(CHAR_TILDE);
                default: ;
            endcase
            if (num_text.size() == 0) num_text.push_back(CHAR_MINUS);
            flush_text();
        end
    endtask

    // Wait until every character is in and every result is out
    task automatic drain_results();
        do @(posedge aclk);
        while (pending_chars.size() != 0 || s_valid || expected_numbers.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_radix(input int unsigned r);
        logic [31:0] wr;
        wr = $urandom();
        wr[5:0] = r[5:0];
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= '0;
        pwdata <= wr;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk);
        while (!pready);
        cfg_radix = wr[5:0];
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Character driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !char_taken) begin
            // hold the offered character until it is taken
        end else if (src_gap > 0) begin
            s_valid <= 1'b0;
            src_gap--;
        end else if (pending_chars.size() > 0) begin
            cur_item = pending_chars.pop_front();
            s_char_code <= cur_item.code;
            s_is_last <= cur_item.last;
            s_valid <= 1'b1;
            if ($urandom_range(0, 63) == 0) src_quiet = !src_quiet;
            src_gap = pick_gap(src_quiet);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Result sink with random stalls and a few long hold-offs
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if ((holds_done == 0 && results_seen >= 20) ||
                (holds_done == 1 && results_seen >= 70)) begin
                snk_hold = LONG_HOLD;
                holds_done++;
            end
            if (snk_hold > 0) begin
                m_ready <= 1'b0;
                snk_hold--;
            end else if (snk_stall > 0) begin
                m_ready <= 1'b0;
                snk_stall--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 63) == 0) snk_quiet = !snk_quiet;
                if ($urandom_range(0, 99) < 30) snk_stall = pick_gap(snk_quiet);
            end
        end
    end

    // Predict on accepted characters, check accepted results
    always @(posedge aclk) begin
        if (!aresetn) begin
            char_taken <= 1'b0;
        end else begin
            char_taken <= s_valid && s_ready;
            if (s_valid && s_ready) parse_char(s_char_code, s_is_last);
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_numbers.size() == 0) begin
                    $error("unexpected result transfer: value %0d ok %0b", m_value, m_ok);
                    mismatch_count++;
                end else begin
                    automatic number_t want = expected_numbers.pop_front();
                    if (m_value !== want.value) begin
                        $error("value: expected %0d, got %0d", $signed(want.value), m_value);
                        mismatch_count++;
                    end
                    if (m_ok !== want.ok) begin
                        $error("ok: expected %0b, got %0b", want.ok, m_ok);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** digit_string_to_integer: FAILED **");
            $finish;
        end
    end

    // Test sequence
    initial begin
        int unsigned radix_plan[9];
        radix_plan = '{36, 2, 0, 1, 63, 16, 40, 7, 10};
        radix_plan[6] = $urandom_range(37, 63);
        radix_plan[8] = $urandom_range(3, 35);

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // sign alone, single digit, letter above base, lower case, late sign
        push_text("+");
        push_text("-");
        push_text("~");
        push_text("9");
        push_text("Z");
        push_text("a");
        push_text("1-");
        push_text("~0");
        push_char(8'hFF, 1'b1);
        while (pending_chars.size() < 75) push_random_string();

        foreach (radix_plan[p]) begin
            drain_results();
            write_radix(radix_plan[p]);
            if (p == 0) begin
                // magnitude limits in base 36: negative edge fits, positive overflows
                spell_number(64'h8000_0000, 36);
                num_text.push_front(CHAR_MINUS);
                flush_text();
                spell_number(64'h8000_0000, 36);
                num_text.push_front(CHAR_PLUS);
                flush_text();
                spell_number(64'h7FFF_FFFF, 36);
                num_text.push_front(CHAR_TILDE);
                flush_text();
            end
            while (pending_chars.size() < 55) push_random_string();
        end
        drain_results();

        if (mismatch_count == 0) begin
            $display("** digit_string_to_integer: PASSED **");
        end else begin
            $display("** digit_string_to_integer: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
design/dsti_pkg.sv
design/dsti_front.sv
design/dsti_fifo.sv
design/dsti_back.sv
design/digit_string_to_integer.sv
test/tb_digit_string_to_integer.sv
